@@ src/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, types and the multiply-accumulate step sequence of the
// ray/triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int NUM_VERTS       = 3;
    localparam int NUM_STEPS       = 36;
    localparam int STEP_W          = 6;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RAY  = 1'b1;

    typedef enum logic [4:0] {
        SRC_D0, SRC_D1, SRC_D2,
        SRC_T0, SRC_T1, SRC_T2,
        SRC_E1_0, SRC_E1_1, SRC_E1_2,
        SRC_E2_0, SRC_E2_1, SRC_E2_2,
        SRC_P0, SRC_P1, SRC_P2,
        SRC_Q0, SRC_Q1, SRC_Q2
    } t_src;

    typedef enum logic [3:0] {
        DST_P0, DST_P1, DST_P2,
        DST_Q0, DST_Q1, DST_Q2,
        DST_DET, DST_NU, DST_NV, DST_NT
    } t_dst;

    typedef struct packed {
        t_src a;
        t_src b;
        logic hi;
        logic neg;
        logic first;
        logic last;
        t_dst dst;
    } t_step;

    function automatic t_step mk(t_src a, t_src b, logic hi, logic neg,
                                 logic first, logic last, t_dst dst);
        t_step s;
        s.a     = a;
        s.b     = b;
        s.hi    = hi;
        s.neg   = neg;
        s.first = first;
        s.last  = last;
        s.dst   = dst;
        return s;
    endfunction

    // Cross products first, then the four dot products. A dot product term
    // with a wide operand takes two steps, low half and then high half.
    function automatic t_step step_rom(logic [STEP_W-1:0] idx);
        t_step s;
        s = mk(SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, 1'b0, DST_P0);
        unique case (idx)
            6'd0:  s = mk(SRC_D1, SRC_E2_2, 1'b0, 1'b0, 1'b1, 1'b0, DST_P0);
            6'd1:  s = mk(SRC_D2, SRC_E2_1, 1'b0, 1'b1, 1'b0, 1'b1, DST_P0);
            6'd2:  s = mk(SRC_D2, SRC_E2_0, 1'b0, 1'b0, 1'b1, 1'b0, DST_P1);
            6'd3:  s = mk(SRC_D0, SRC_E2_2, 1'b0, 1'b1, 1'b0, 1'b1, DST_P1);
            6'd4:  s = mk(SRC_D0, SRC_E2_1, 1'b0, 1'b0, 1'b1, 1'b0, DST_P2);
            6'd5:  s = mk(SRC_D1, SRC_E2_0, 1'b0, 1'b1, 1'b0, 1'b1, DST_P2);
            6'd6:  s = mk(SRC_T1, SRC_E1_2, 1'b0, 1'b0, 1'b1, 1'b0, DST_Q0);
            6'd7:  s = mk(SRC_T2, SRC_E1_1, 1'b0, 1'b1, 1'b0, 1'b1, DST_Q0);
            6'd8:  s = mk(SRC_T2, SRC_E1_0, 1'b0, 1'b0, 1'b1, 1'b0, DST_Q1);
            6'd9:  s = mk(SRC_T0, SRC_E1_2, 1'b0, 1'b1, 1'b0, 1'b1, DST_Q1);
            6'd10: s = mk(SRC_T0, SRC_E1_1, 1'b0, 1'b0, 1'b1, 1'b0, DST_Q2);
            6'd11: s = mk(SRC_T1, SRC_E1_0, 1'b0, 1'b1, 1'b0, 1'b1, DST_Q2);
            6'd12: s = mk(SRC_P0, SRC_E1_0, 1'b0, 1'b0, 1'b1, 1'b0, DST_DET);
            6'd13: s = mk(SRC_P0, SRC_E1_0, 1'b1, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd14: s = mk(SRC_P1, SRC_E1_1, 1'b0, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd15: s = mk(SRC_P1, SRC_E1_1, 1'b1, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd16: s = mk(SRC_P2, SRC_E1_2, 1'b0, 1'b0, 1'b0, 1'b0, DST_DET);
            6'd17: s = mk(SRC_P2, SRC_E1_2, 1'b1, 1'b0, 1'b0, 1'b1, DST_DET);
            6'd18: s = mk(SRC_P0, SRC_T0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NU);
            6'd19: s = mk(SRC_P0, SRC_T0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd20: s = mk(SRC_P1, SRC_T1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd21: s = mk(SRC_P1, SRC_T1, 1'b1, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd22: s = mk(SRC_P2, SRC_T2, 1'b0, 1'b0, 1'b0, 1'b0, DST_NU);
            6'd23: s = mk(SRC_P2, SRC_T2, 1'b1, 1'b0, 1'b0, 1'b1, DST_NU);
            6'd24: s = mk(SRC_Q0, SRC_D0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NV);
            6'd25: s = mk(SRC_Q0, SRC_D0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd26: s = mk(SRC_Q1, SRC_D1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd27: s = mk(SRC_Q1, SRC_D1, 1'b1, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd28: s = mk(SRC_Q2, SRC_D2, 1'b0, 1'b0, 1'b0, 1'b0, DST_NV);
            6'd29: s = mk(SRC_Q2, SRC_D2, 1'b1, 1'b0, 1'b0, 1'b1, DST_NV);
            6'd30: s = mk(SRC_Q0, SRC_E2_0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NT);
            6'd31: s = mk(SRC_Q0, SRC_E2_0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd32: s = mk(SRC_Q1, SRC_E2_1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd33: s = mk(SRC_Q1, SRC_E2_1, 1'b1, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd34: s = mk(SRC_Q2, SRC_E2_2, 1'b0, 1'b0, 1'b0, 1'b0, DST_NT);
            6'd35: s = mk(SRC_Q2, SRC_E2_2, 1'b1, 1'b0, 1'b0, 1'b1, DST_NT);
            default: s = mk(SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, 1'b0, DST_P0);
        endcase
        return s;
    endfunction

endpackage

@@ src/rti_front.sv @@
// ----------------------------------------------------------------------------
// rti_front
// Input side: holds the stored triangle, applies vertex loads and turns each
// ray into direction, edges and origin offset words for the queue.
// ----------------------------------------------------------------------------
module rti_front #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
    parameter int QW          = 12 * COORD_WIDTH + 9
) (
    input  logic                          i_clk,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [1:0]                    i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  logic                          i_room,
    output logic                          o_push,
    output logic [QW-1:0]                 o_data
);

    localparam int W  = COORD_WIDTH;
    localparam int HW = COORD_WIDTH + 1;

    logic signed [W-1:0]  r_vtx [rti_pkg::NUM_VERTS][3];
    logic signed [W-1:0]  org [3];
    logic signed [W-1:0]  dir [3];
    logic signed [HW-1:0] e1 [3];
    logic signed [HW-1:0] e2 [3];
    logic signed [HW-1:0] t [3];
    logic                 accept;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;
    assign o_push  = accept && (i_mode == rti_pkg::MODE_RAY);

    assign org[0] = i_coord_x;
    assign org[1] = i_coord_y;
    assign org[2] = i_coord_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = HW'(r_vtx[1][k]) - HW'(r_vtx[0][k]);
            e2[k] = HW'(r_vtx[2][k]) - HW'(r_vtx[0][k]);
            t[k]  = HW'(org[k]) - HW'(r_vtx[0][k]);
        end
    end

    assign o_data = {t[2], t[1], t[0], e2[2], e2[1], e2[0],
                     e1[2], e1[1], e1[0], dir[2], dir[1], dir[0]};

    always_ff @(posedge i_clk) begin
        if (accept && (i_mode == rti_pkg::MODE_LOAD)
                && (i_vertex_index < 2'(rti_pkg::NUM_VERTS))) begin
            for (int k = 0; k < 3; k++) begin
                r_vtx[i_vertex_index][k] <= org[k];
            end
        end
    end

endmodule

@@ src/rti_queue.sv @@
// ----------------------------------------------------------------------------
// rti_queue
// Short first-in first-out queue that decouples the input side from the
// arithmetic side.
// ----------------------------------------------------------------------------
module rti_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rti_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_room,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_room  = i_rst_n && (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/rti_div.sv @@
// ----------------------------------------------------------------------------
// rti_div
// Radix-2 restoring divider: forms num * 2^FRAC_BITS / det on magnitudes,
// one quotient bit per cycle, then saturates to the signed output range.
// ----------------------------------------------------------------------------
module rti_div #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF,
    parameter int ACC_W       = 3 * COORD_WIDTH + 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ACC_W-1:0]       i_num,
    input  logic [ACC_W-1:0]              i_det,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_quot
);

    localparam int W     = COORD_WIDTH;
    localparam int NW    = ACC_W + FRAC_BITS + COORD_WIDTH;
    localparam int CNT_W = $clog2(COORD_WIDTH + 1);

    logic [ACC_W-1:0] mag;
    logic [NW-1:0]    n_ext;
    logic [NW-1:0]    d_ext;
    logic [ACC_W:0]   rem2;
    logic             ge;
    logic [W-1:0]     maxp;
    logic [W-1:0]     lim;
    logic [W-1:0]     sel;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_rem;
    logic [W-1:0]     r_low;
    logic [W-1:0]     r_q;
    logic [ACC_W-1:0] r_det;
    logic             r_neg;
    logic             r_ovf;
    logic [W-1:0]     r_quot;

    assign mag   = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign n_ext = NW'(mag) << FRAC_BITS;
    assign d_ext = NW'(i_det) << COORD_WIDTH;
    assign rem2  = {r_rem, r_low[W-1]};
    assign ge    = (rem2 >= {1'b0, r_det});
    assign maxp  = {1'b0, {(W-1){1'b1}}};
    assign lim   = r_neg ? maxp + 1'b1 : maxp;
    assign sel   = (r_ovf || (r_q > lim)) ? lim : r_q;

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
                r_neg  <= i_num[ACC_W-1];
                r_ovf  <= (n_ext >= d_ext);
                r_rem  <= n_ext[ACC_W+W-1:W];
                r_low  <= n_ext[W-1:0];
                r_det  <= i_det;
                r_q    <= '0;
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    r_rem <= ge ? ACC_W'(rem2 - {1'b0, r_det}) : ACC_W'(rem2);
                    r_low <= {r_low[W-2:0], 1'b0};
                    r_q   <= {r_q[W-2:0], ge};
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= r_neg ? W'(-sel) : sel;
                end
            end
        end
    end

endmodule

@@ src/rti_back.sv @@
// ----------------------------------------------------------------------------
// rti_back
// Arithmetic side: one shared signed multiplier and accumulator steps
// through the cross and dot products, then for a non-parallel ray three
// dividers form the distance and barycentrics and the result word is held.
// ----------------------------------------------------------------------------
module rti_back #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF,
    parameter int QW          = 12 * COORD_WIDTH + 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [QW-1:0]                 i_q_data,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic                          o_ray_parallel,
    output logic signed [COORD_WIDTH-1:0] o_plane_distance,
    output logic signed [COORD_WIDTH-1:0] o_bary_u,
    output logic signed [COORD_WIDTH-1:0] o_bary_v
);

    localparam int W     = COORD_WIDTH;
    localparam int HW    = COORD_WIDTH + 1;
    localparam int AW    = HW + 1;
    localparam int WV    = 2 * HW + 1;
    localparam int PW    = 2 * HW + 1;
    localparam int ACC_W = 3 * HW + 3;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_NEG, S_CHK, S_DIV, S_OUT
    } t_state;

    t_state                r_state;
    logic [rti_pkg::STEP_W-1:0] r_issue;
    rti_pkg::t_step        r_pstep;
    logic                  r_pvalid;
    logic signed [PW-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [W-1:0]   r_d [3];
    logic signed [HW-1:0]  r_e1 [3];
    logic signed [HW-1:0]  r_e2 [3];
    logic signed [HW-1:0]  r_t [3];
    logic signed [WV-1:0]  r_p [3];
    logic signed [WV-1:0]  r_q [3];
    logic signed [ACC_W-1:0] r_det;
    logic signed [ACC_W-1:0] r_nu;
    logic signed [ACC_W-1:0] r_nv;
    logic signed [ACC_W-1:0] r_nt;
    logic                  r_zero;
    logic                  r_div_start;
    logic                  r_hit;
    logic                  r_par;
    logic signed [W-1:0]   r_dist;
    logic signed [W-1:0]   r_u;
    logic signed [W-1:0]   r_v;

    rti_pkg::t_step        cur;
    logic                  issue;
    logic signed [WV-1:0]  wsel;
    logic signed [HW-1:0]  nsel;
    logic signed [AW-1:0]  a_nar;
    logic                  a_wide;
    logic signed [AW-1:0]  a_val;
    logic signed [HW-1:0]  b_val;
    logic signed [ACC_W-1:0] prod_x;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_n;
    logic signed [ACC_W+1:0] det_x;
    logic signed [ACC_W+1:0] nu_x;
    logic signed [ACC_W+1:0] nv_x;
    logic signed [ACC_W+1:0] du;
    logic signed [ACC_W+1:0] duv;
    logic                  hit_c;
    logic                  done_t;
    logic                  done_u;
    logic                  done_v;
    logic signed [W-1:0]   q_t;
    logic signed [W-1:0]   q_u;
    logic signed [W-1:0]   q_v;
    logic [W-1:0]          maxp;

    assign maxp  = {1'b0, {(W-1){1'b1}}};
    assign cur   = rti_pkg::step_rom(r_issue);
    assign issue = (r_state == S_MAC) && (r_issue < rti_pkg::STEP_W'(rti_pkg::NUM_STEPS));
    assign o_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        wsel   = r_p[0];
        nsel   = r_e1[0];
        a_wide = 1'b0;
        unique case (cur.a)
            rti_pkg::SRC_D0: nsel = r_d[0];
            rti_pkg::SRC_D1: nsel = r_d[1];
            rti_pkg::SRC_D2: nsel = r_d[2];
            rti_pkg::SRC_T0: nsel = r_t[0];
            rti_pkg::SRC_T1: nsel = r_t[1];
            rti_pkg::SRC_T2: nsel = r_t[2];
            rti_pkg::SRC_P0: begin wsel = r_p[0]; a_wide = 1'b1; end
            rti_pkg::SRC_P1: begin wsel = r_p[1]; a_wide = 1'b1; end
            rti_pkg::SRC_P2: begin wsel = r_p[2]; a_wide = 1'b1; end
            rti_pkg::SRC_Q0: begin wsel = r_q[0]; a_wide = 1'b1; end
            rti_pkg::SRC_Q1: begin wsel = r_q[1]; a_wide = 1'b1; end
            rti_pkg::SRC_Q2: begin wsel = r_q[2]; a_wide = 1'b1; end
            default: nsel = r_e1[0];
        endcase
        a_nar = nsel;
        if (!a_wide) begin
            a_val = a_nar;
        end else if (cur.hi) begin
            a_val = wsel[WV-1:HW];
        end else begin
            a_val = {1'b0, wsel[HW-1:0]};
        end

        unique case (cur.b)
            rti_pkg::SRC_D0:   b_val = r_d[0];
            rti_pkg::SRC_D1:   b_val = r_d[1];
            rti_pkg::SRC_D2:   b_val = r_d[2];
            rti_pkg::SRC_T0:   b_val = r_t[0];
            rti_pkg::SRC_T1:   b_val = r_t[1];
            rti_pkg::SRC_T2:   b_val = r_t[2];
            rti_pkg::SRC_E1_0: b_val = r_e1[0];
            rti_pkg::SRC_E1_1: b_val = r_e1[1];
            rti_pkg::SRC_E1_2: b_val = r_e1[2];
            rti_pkg::SRC_E2_0: b_val = r_e2[0];
            rti_pkg::SRC_E2_1: b_val = r_e2[1];
            rti_pkg::SRC_E2_2: b_val = r_e2[2];
            default:           b_val = '0;
        endcase
    end

    always_comb begin
        prod_x   = r_prod;
        term     = r_pstep.hi ? (prod_x <<< HW) : prod_x;
        acc_base = r_pstep.first ? '0 : r_acc;
        acc_n    = r_pstep.neg ? acc_base - term : acc_base + term;
    end

    always_comb begin
        det_x = r_det;
        nu_x  = r_nu;
        nv_x  = r_nv;
        du    = det_x - nu_x;
        duv   = det_x - nu_x - nv_x;
        hit_c = !nu_x[ACC_W+1] && !du[ACC_W+1] && !nv_x[ACC_W+1] && !duv[ACC_W+1];
    end

    rti_div #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_W      (ACC_W)
    ) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (r_nt),
        .i_det  (r_det),
        .o_done (done_t),
        .o_quot (q_t)
    );

    rti_div #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_W      (ACC_W)
    ) u_div_u (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (r_nu),
        .i_det  (r_det),
        .o_done (done_u),
        .o_quot (q_u)
    );

    rti_div #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_W      (ACC_W)
    ) u_div_v (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (r_nv),
        .i_det  (r_det),
        .o_done (done_v),
        .o_quot (q_v)
    );

    assign o_valid          = (r_state == S_OUT);
    assign o_hit            = r_hit;
    assign o_ray_parallel   = r_par;
    assign o_plane_distance = r_dist;
    assign o_bary_u         = r_u;
    assign o_bary_v         = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_pvalid    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_pvalid    <= issue;
            if (issue) begin
                r_prod  <= a_val * b_val;
                r_pstep <= cur;
                r_issue <= r_issue + 1'b1;
            end
            if (r_pvalid) begin
                r_acc <= acc_n;
                if (r_pstep.last) begin
                    unique case (r_pstep.dst)
                        rti_pkg::DST_P0:  r_p[0] <= acc_n[WV-1:0];
                        rti_pkg::DST_P1:  r_p[1] <= acc_n[WV-1:0];
                        rti_pkg::DST_P2:  r_p[2] <= acc_n[WV-1:0];
                        rti_pkg::DST_Q0:  r_q[0] <= acc_n[WV-1:0];
                        rti_pkg::DST_Q1:  r_q[1] <= acc_n[WV-1:0];
                        rti_pkg::DST_Q2:  r_q[2] <= acc_n[WV-1:0];
                        rti_pkg::DST_DET: r_det  <= acc_n;
                        rti_pkg::DST_NU:  r_nu   <= acc_n;
                        rti_pkg::DST_NV:  r_nv   <= acc_n;
                        rti_pkg::DST_NT:  r_nt   <= acc_n;
                        default:          r_nt   <= r_nt;
                    endcase
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        for (int k = 0; k < 3; k++) begin
                            r_d[k]  <= i_q_data[k*W +: W];
                            r_e1[k] <= i_q_data[3*W + k*HW +: HW];
                            r_e2[k] <= i_q_data[3*W + 3*HW + k*HW +: HW];
                            r_t[k]  <= i_q_data[3*W + 6*HW + k*HW +: HW];
                        end
                        r_issue <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_pvalid && r_pstep.last && (r_pstep.dst == rti_pkg::DST_NT)) begin
                        r_state <= S_NEG;
                    end
                end
                S_NEG: begin
                    r_zero <= (r_det == '0);
                    if (r_det[ACC_W-1]) begin
                        r_det <= -r_det;
                        r_nu  <= -r_nu;
                        r_nv  <= -r_nv;
                        r_nt  <= -r_nt;
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_zero) begin
                        r_hit   <= 1'b0;
                        r_par   <= 1'b1;
                        r_dist  <= maxp;
                        r_u     <= maxp;
                        r_v     <= maxp;
                        r_state <= S_OUT;
                    end else begin
                        r_hit       <= hit_c;
                        r_par       <= 1'b0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (done_t && done_u && done_v) begin
                        r_dist  <= q_t;
                        r_u     <= q_u;
                        r_v     <= q_v;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/ray_triangle_intersect_top.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Fixed-point ray/triangle intersection: vertex loads fill the stored
// triangle, each ray gives hit, parallel flag, distance and barycentrics.
//
//   channel | direction | handshake           | word
//   input   | in        | i_valid / o_ready   | mode, vertex index, coords, dir
//   result  | out       | o_valid / i_ready   | hit, parallel, distance, u, v
//
// A load gives no result. A ray passes through 36 steps of the one shared
// multiplier, then COORD_WIDTH steps of the radix-2 dividers. A parallel
// ray skips the division. A two-word queue lets input be taken while the
// arithmetic side works or while a result waits. Reset is synchronous and
// clears control state only.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [1:0]                    i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic                          o_ray_parallel,
    output logic signed [COORD_WIDTH-1:0] o_plane_distance,
    output logic signed [COORD_WIDTH-1:0] o_bary_u,
    output logic signed [COORD_WIDTH-1:0] o_bary_v
);

    localparam int HW = COORD_WIDTH + 1;
    localparam int QW = 3 * COORD_WIDTH + 9 * HW;

    logic          push;
    logic          room;
    logic [QW-1:0] push_data;
    logic          pop;
    logic          q_valid;
    logic [QW-1:0] q_data;

    rti_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .QW         (QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_vertex_index(i_vertex_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_room        (room),
        .o_push        (push),
        .o_data        (push_data)
    );

    rti_queue #(
        .WIDTH(QW),
        .DEPTH(rti_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_data),
        .o_room (room),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    rti_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .QW         (QW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_ray_parallel  (o_ray_parallel),
        .o_plane_distance(o_plane_distance),
        .o_bary_u        (o_bary_u),
        .o_bary_v        (o_bary_v)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> room)
        else $error("Ray word pushed into a full queue.");

    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("Queue popped while empty.");

    a_parallel_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ray_parallel) |-> !o_hit)
        else $error("Parallel ray reported as a hit.");

    a_taken_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> !o_valid)
        else $error("Result word shown again after it was taken.");

endmodule

@@ dv/rti_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rti_checker
// Watches both channels of the ray/triangle block, keeps its own copy of the
// stored triangle, computes the expected hit, parallel flag, distance and
// barycentrics of every accepted ray, and compares each result word in order.
// ----------------------------------------------------------------------------
module rti_checker #(
    parameter int CW = 24,
    parameter int FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_in_ready,
    input  logic                 i_mode,
    input  logic [1:0]           i_vertex_index,
    input  logic signed [CW-1:0] i_coord_x,
    input  logic signed [CW-1:0] i_coord_y,
    input  logic signed [CW-1:0] i_coord_z,
    input  logic signed [CW-1:0] i_dir_x,
    input  logic signed [CW-1:0] i_dir_y,
    input  logic signed [CW-1:0] i_dir_z,
    input  logic                 i_out_valid,
    input  logic                 i_ready,
    input  logic                 i_hit,
    input  logic                 i_ray_parallel,
    input  logic signed [CW-1:0] i_plane_distance,
    input  logic signed [CW-1:0] i_bary_u,
    input  logic signed [CW-1:0] i_bary_v,
    output int                   o_errors,
    output int                   o_pending
);

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic                 hit;
        logic                 par;
        logic signed [CW-1:0] pdist;
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
    } t_hit_rec;

    logic signed [CW-1:0] tri_vert [rti_pkg::NUM_VERTS][3];
    t_hit_rec             expected_hits [$];

    function automatic logic signed [CW-1:0] quotient(t_wide n, t_wide d);
        t_wide mag;
        t_wide q;
        t_wide lim;
        logic  neg;
        neg = n < 0;
        mag = neg ? -n : n;
        q   = (mag <<< FB) / d;
        lim = neg ? (t_wide'(1) <<< (CW-1)) : (t_wide'(1) <<< (CW-1)) - 1;
        if (q > lim) q = lim;
        return neg ? CW'(-q) : CW'(q);
    endfunction

    function automatic t_hit_rec cast_ray(logic signed [CW-1:0] o[3],
                                          logic signed [CW-1:0] d[3]);
        t_wide    e1[3], e2[3], t[3], p[3], q[3], dv[3];
        t_wide    det, nu, nv, nt;
        t_hit_rec r;
        for (int k = 0; k < 3; k++) begin
            e1[k] = t_wide'(tri_vert[1][k]) - t_wide'(tri_vert[0][k]);
            e2[k] = t_wide'(tri_vert[2][k]) - t_wide'(tri_vert[0][k]);
            t[k]  = t_wide'(o[k]) - t_wide'(tri_vert[0][k]);
            dv[k] = t_wide'(d[k]);
        end
        p[0] = dv[1]*e2[2] - dv[2]*e2[1];
        p[1] = dv[2]*e2[0] - dv[0]*e2[2];
        p[2] = dv[0]*e2[1] - dv[1]*e2[0];
        det  = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
        if (det == 0) begin
            r.hit   = 1'b0;
            r.par   = 1'b1;
            r.pdist = {1'b0, {(CW-1){1'b1}}};
            r.u     = r.pdist;
            r.v     = r.pdist;
            return r;
        end
        q[0] = t[1]*e1[2] - t[2]*e1[1];
        q[1] = t[2]*e1[0] - t[0]*e1[2];
        q[2] = t[0]*e1[1] - t[1]*e1[0];
        nu = p[0]*t[0] + p[1]*t[1] + p[2]*t[2];
        nv = q[0]*dv[0] + q[1]*dv[1] + q[2]*dv[2];
        nt = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
        if (det < 0) begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        r.hit   = (nu >= 0) && (nu <= det) && (nv >= 0) && (nu + nv <= det);
        r.par   = 1'b0;
        r.pdist = quotient(nt, det);
        r.u     = quotient(nu, det);
        r.v     = quotient(nv, det);
        return r;
    endfunction

    assign o_pending = expected_hits.size();

    always @(posedge i_clk) begin
        logic signed [CW-1:0] org[3];
        logic signed [CW-1:0] dir[3];
        t_hit_rec             want;
        t_hit_rec             got;
        if (!i_rst_n) begin
            o_errors <= 0;
            expected_hits.delete();
        end else begin
            if (i_valid && i_in_ready) begin
                org = '{i_coord_x, i_coord_y, i_coord_z};
                dir = '{i_dir_x, i_dir_y, i_dir_z};
                if (i_mode == rti_pkg::MODE_RAY) begin
                    expected_hits.insert(expected_hits.size(), cast_ray(org, dir));
                end else if (i_vertex_index < rti_pkg::NUM_VERTS) begin
                    tri_vert[i_vertex_index] = org;
                end
            end
            if (i_out_valid && i_ready) begin
                got = '{i_hit, i_ray_parallel, i_plane_distance, i_bary_u, i_bary_v};
                if (expected_hits.size() == 0) begin
                    if (o_errors < 10) $display("Unexpected result word %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (want !== got) begin
                        if (o_errors < 10) begin
                            $display({"Mismatch: hit %b/%b par %b/%b distance %h/%h",
                                      " u %h/%h v %h/%h"},
                                     want.hit, got.hit, want.par, got.par, want.pdist,
                                     got.pdist, want.u, got.u, want.v, got.v);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertex loads and rays into the ray/triangle block under several
// idling phases, with a long receiver hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW   = 24;
    localparam int MAXC = (1 <<< (CW - 1)) - 1;
    localparam int MINC = -(1 <<< (CW - 1));

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 mode;
    logic [1:0]           vidx;
    logic signed [CW-1:0] cx, cy, cz, dx, dy, dz;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit, par;
    logic signed [CW-1:0] pdist, bu, bv;
    int                   errors;
    int                   pending;
    int                   cycles;
    int                   send_idle;
    int                   stall_pct;
    int                   hold_off;
    bit                   hold_req;
    bit                   hold_used;

    ray_triangle_intersect_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_mode(mode), .i_vertex_index(vidx),
        .i_coord_x(cx), .i_coord_y(cy), .i_coord_z(cz),
        .i_dir_x(dx), .i_dir_y(dy), .i_dir_z(dz),
        .o_valid(out_valid), .i_ready(out_ready), .o_hit(hit),
        .o_ray_parallel(par), .o_plane_distance(pdist), .o_bary_u(bu), .o_bary_v(bv)
    );

    rti_checker #(.CW(CW), .FB(16)) i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_mode(mode), .i_vertex_index(vidx),
        .i_coord_x(cx), .i_coord_y(cy), .i_coord_z(cz),
        .i_dir_x(dx), .i_dir_y(dy), .i_dir_z(dz),
        .i_out_valid(out_valid), .i_ready(out_ready), .i_hit(hit),
        .i_ray_parallel(par), .i_plane_distance(pdist), .i_bary_u(bu), .i_bary_v(bv),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_off  <= 600;
            out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    function automatic int rnd_coord();
        int sel;
        int r;
        sel = int'($urandom_range(5));
        unique case (sel)
            0: r = MAXC;
            1: r = MINC;
            2: r = int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
            3: r = int'($urandom_range(0, 2 ** 20)) - 2 ** 19;
            default: r = int'($urandom_range(0, 2 ** CW - 1)) + MINC;
        endcase
        return r;
    endfunction

    task automatic send(input logic m, input logic [1:0] vi,
                        input int x, y, z, ex, ey, ez);
        while (int'($urandom_range(99)) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        vidx     <= vi;
        cx <= CW'(x); cy <= CW'(y); cz <= CW'(z);
        dx <= CW'(ex); dy <= CW'(ey); dz <= CW'(ez);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic load_tri(input int a[9]);
        for (int i = 0; i < 3; i++) begin
            send(rti_pkg::MODE_LOAD, 2'(i), a[3*i], a[3*i+1], a[3*i+2], rnd_coord(),
                 rnd_coord(), rnd_coord());
        end
    endtask

    task automatic rand_tri();
        int a[9];
        int sc;
        sc = int'($urandom_range(3));
        foreach (a[i]) a[i] = (sc == 3) ? rnd_coord()
                              : int'($urandom_range(0, 2 ** 19)) - 2 ** 18;
        load_tri(a);
    endtask

    task automatic rand_ray();
        int o[3], d[3];
        foreach (o[i]) begin
            o[i] = ($urandom_range(3) == 0) ? rnd_coord()
                   : int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
            d[i] = ($urandom_range(3) == 0) ? rnd_coord()
                   : int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
        end
        if ($urandom_range(9) == 0) d[2] = 0;
        send(rti_pkg::MODE_RAY, 2'($urandom), o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int unit_tri[9];
        int phase_len;
        send_idle = 0; stall_pct = 0; hold_req = 1'b0;
        rst_n = 1'b0; in_valid = 1'b0;
        mode = rti_pkg::MODE_LOAD; vidx = 2'd0;
        cx = '0; cy = '0; cz = '0; dx = '0; dy = '0; dz = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        unit_tri = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};
        load_tri(unit_tri);
        send(rti_pkg::MODE_RAY, 2'd0, 16384, 16384, 65536, 0, 0, -65536);
        send(rti_pkg::MODE_RAY, 2'd3, 0, 0, 65536, 0, 0, -65536);
        send(rti_pkg::MODE_RAY, 2'd1, 65536, 0, 65536, 0, 0, -65536);
        send(rti_pkg::MODE_RAY, 2'd2, 32768, 32768, 65536, 0, 0, -65536);
        send(rti_pkg::MODE_RAY, 2'd0, -16384, 16384, 65536, 0, 0, 65536);
        send(rti_pkg::MODE_RAY, 2'd0, 16384, 16384, 0, 65536, 0, 0);
        send(rti_pkg::MODE_RAY, 2'd0, 16384, 16384, 65536, 0, 0, -1);
        send(rti_pkg::MODE_RAY, 2'd0, MAXC, MINC, MAXC, MINC, MAXC, MINC);
        send(rti_pkg::MODE_RAY, 2'd0, MINC, MINC, MINC, MAXC, MAXC, MAXC);
        send(rti_pkg::MODE_LOAD, 2'd3, MAXC, MAXC, MAXC, 0, 0, 0);
        send(rti_pkg::MODE_RAY, 2'd0, 16384, 16384, 65536, 0, 0, 65536);
        unit_tri = '{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC};
        load_tri(unit_tri);
        send(rti_pkg::MODE_RAY, 2'd1, 0, 0, 0, 1, 1, 1);
        send(rti_pkg::MODE_RAY, 2'd1, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 37) : 0;
            stall_pct = (ph == 2) ? 71 : ((ph == 3) ? 37 : 0);
            if (ph == 0) hold_req = 1'b1;
            phase_len = 380;
            while (phase_len > 0) begin
                if ($urandom_range(15) == 0) begin
                    rand_tri();
                end else if ($urandom_range(40) == 0) begin
                    send(rti_pkg::MODE_LOAD, 2'd3, rnd_coord(), rnd_coord(), rnd_coord(),
                         0, 0, 0);
                end else begin
                    rand_ray();
                    phase_len--;
                end
            end
            drain();
        end
        stall_pct = 0;
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/rti_pkg.sv
src/rti_front.sv
src/rti_queue.sv
src/rti_div.sv
src/rti_back.sv
src/ray_triangle_intersect_top.sv
dv/rti_checker.sv
dv/testbench.sv
